// ===== rtl/assert_macros.svh =====
// Assertion macros used by the RTL module.
// Empty bodies when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMPLIES(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, pre, post)
`define ASSERT_NEXT(label, clk, rst_n, pre, post)
`endif
`endif

// ===== rtl/rjac_pkg.sv =====
// Package for the reconnection Jacobian block: widths, codes, shared types.
// Depends on nothing.
`timescale 1ns / 1ps
package rjac_pkg;
  localparam int unsigned CoordWidth  = 32;
  localparam int unsigned NormalWidth = 16;
  localparam int unsigned NormalFrac  = NormalWidth - 2;
  localparam int unsigned MagWidth    = CoordWidth;
  localparam int unsigned SqWidth     = 2 * MagWidth + 2;
  localparam int unsigned RootWidth   = SqWidth / 2;
  localparam int unsigned DotWidth    = MagWidth + NormalWidth + 2;
  localparam int unsigned CosWidth    = 17;
  localparam int unsigned JacWidth    = 32;
  localparam int unsigned NumWidth    = CosWidth + SqWidth + 16;
  localparam int unsigned DenWidth    = CosWidth + SqWidth;
  localparam int unsigned CosNumWidth = DotWidth + 16;
  localparam int unsigned CosDenWidth = RootWidth + NormalFrac;
  localparam int unsigned AddrWidth   = 3;

  localparam logic [AddrWidth-1:0] AddrMinDist = 3'd0;
  localparam logic [AddrWidth-1:0] AddrMinCos  = 3'd4;

  typedef enum logic [1:0] {
    OutNormal    = 2'd0,
    OutTooClose  = 2'd1,
    OutGrazing   = 2'd2,
    OutSaturated = 2'd3
  } outcome_e;
endpackage

// ===== rtl/reconnection_jacobian.sv =====
// Reconnection shift Jacobian: fixed-latency pipeline, one item per cycle.
// Stages: difference, square, sum, root, cosine division, clamp, product, Jacobian
// division, output. Throughput: one transfer per cycle; busy is held low. The divider
// and root stages resolve one restoring bit per stage, which sets the depth. Reset
// clears valid bits and restores register defaults; the receiver cannot stall.
`timescale 1ns / 1ps
module reconnection_jacobian (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  output logic busy,
  input  logic signed [31:0] old_origin_x_i, old_origin_y_i, old_origin_z_i,
  input  logic signed [31:0] new_origin_x_i, new_origin_y_i, new_origin_z_i,
  input  logic signed [31:0] hit_x_i, hit_y_i, hit_z_i,
  input  logic signed [15:0] normal_x_i, normal_y_i, normal_z_i,
  output logic done_o,
  output logic [31:0] jacobian_o,
  output logic [1:0] outcome_o,
  input  logic psel, penable, pwrite,
  input  logic [rjac_pkg::AddrWidth-1:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic pready
);
`include "assert_macros.svh"
  localparam int unsigned MW = rjac_pkg::MagWidth;
  localparam int unsigned SW = rjac_pkg::SqWidth;
  localparam int unsigned RW = rjac_pkg::RootWidth;
  localparam int unsigned DW = rjac_pkg::DotWidth;
  localparam int unsigned CW = rjac_pkg::CosWidth;
  localparam int unsigned NW = rjac_pkg::NumWidth;
  localparam int unsigned QW = rjac_pkg::DenWidth;
  localparam int unsigned CNW = rjac_pkg::CosNumWidth;
  localparam int unsigned CDW = rjac_pkg::CosDenWidth;
  localparam int unsigned HW = SW / 2;

  // Config registers
  logic [31:0] min_dist_q;
  logic [16:0] min_cos_q;
  logic cfg_wr;
  assign cfg_wr = psel & penable & pwrite;
  assign pready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_dist_q <= 32'd4295;
      min_cos_q  <= 17'd7;
    end else if (cfg_wr) begin
      if (paddr == rjac_pkg::AddrMinDist) min_dist_q <= pwdata;
      else if (paddr == rjac_pkg::AddrMinCos) min_cos_q <= pwdata[16:0];
    end
  end
  always_comb begin
    unique case (paddr)
      rjac_pkg::AddrMinDist: prdata = min_dist_q;
      rjac_pkg::AddrMinCos:  prdata = {15'd0, min_cos_q};
      default:               prdata = 32'd0;
    endcase
  end
  assign busy = 1'b0;

  // Stage 0: differences and normal magnitudes
  logic v0_q;
  logic [MW-1:0] om_q [3], nm_q [3];
  logic [15:0] lm_q [3];
  logic os_q [3], ns_q [3], ls_q [3];
  logic signed [32:0] dold [3], dnew [3];
  logic signed [31:0] hc [3], oc [3], nc [3];
  logic signed [15:0] nrm [3];
  assign hc = '{hit_x_i, hit_y_i, hit_z_i};
  assign oc = '{old_origin_x_i, old_origin_y_i, old_origin_z_i};
  assign nc = '{new_origin_x_i, new_origin_y_i, new_origin_z_i};
  assign nrm = '{normal_x_i, normal_y_i, normal_z_i};
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      dold[k] = 33'(hc[k]) - 33'(oc[k]);
      dnew[k] = 33'(hc[k]) - 33'(nc[k]);
    end
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v0_q <= 1'b0;
    else v0_q <= start;
  end
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 3; k++) begin
      os_q[k] <= dold[k][32];
      om_q[k] <= dold[k][32] ? MW'(-dold[k]) : MW'(dold[k]);
      ns_q[k] <= dnew[k][32];
      nm_q[k] <= dnew[k][32] ? MW'(-dnew[k]) : MW'(dnew[k]);
      ls_q[k] <= nrm[k][15];
      lm_q[k] <= nrm[k][15] ? 16'(-nrm[k]) : 16'(nrm[k]);
    end
  end

  // Stage 1: squares (one 32x32 product each) and normal.dir products
  logic v1_q;
  logic [2*MW-1:0] osq_q [3], nsq_q [3];
  logic [MW+15:0] op_q [3], np_q [3];
  logic opn_q [3], npn_q [3];
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v1_q <= 1'b0;
    else v1_q <= v0_q;
  end
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 3; k++) begin
      osq_q[k] <= om_q[k] * om_q[k];
      nsq_q[k] <= nm_q[k] * nm_q[k];
      op_q[k] <= om_q[k] * lm_q[k];
      np_q[k] <= nm_q[k] * lm_q[k];
      opn_q[k] <= os_q[k] ^ ls_q[k];
      npn_q[k] <= ns_q[k] ^ ls_q[k];
    end
  end

  // Stage 2: sums, too-close test, absolute dots
  logic v2_q, close2_q;
  logic [SW-1:0] oss_q, nss_q;
  logic [DW-1:0] odot_q, ndot_q;
  logic [SW-1:0] oss_d, nss_d;
  logic signed [DW:0] od_s, nd_s;
  always_comb begin
    oss_d = '0; nss_d = '0; od_s = '0; nd_s = '0;
    for (int k = 0; k < 3; k++) begin
      oss_d += SW'(osq_q[k]);
      nss_d += SW'(nsq_q[k]);
      od_s = opn_q[k] ? od_s - (DW+1)'(op_q[k]) : od_s + (DW+1)'(op_q[k]);
      nd_s = npn_q[k] ? nd_s - (DW+1)'(np_q[k]) : nd_s + (DW+1)'(np_q[k]);
    end
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v2_q <= 1'b0;
    else v2_q <= v1_q;
  end
  always_ff @(posedge clk_i) begin
    oss_q <= oss_d;
    nss_q <= nss_d;
    odot_q <= od_s[DW] ? DW'(-od_s) : DW'(od_s);
    ndot_q <= nd_s[DW] ? DW'(-nd_s) : DW'(nd_s);
    close2_q <= (oss_d <= SW'(min_dist_q)) || (nss_d <= SW'(min_dist_q));
  end

  // Square root pipeline: one result bit per stage for both lengths
  typedef struct packed {
    logic close;
    logic [SW-1:0] oss, nss;
    logic [DW-1:0] odot, ndot;
    logic [RW-1:0] ro, rn;
  } sq_t;
  logic sv_q [RW+1];
  sq_t sp_q [RW+1];
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i <= RW; i++) sv_q[i] <= 1'b0;
    end else begin
      sv_q[0] <= v2_q;
      for (int i = 1; i <= RW; i++) sv_q[i] <= sv_q[i-1];
    end
  end
  always_ff @(posedge clk_i) begin
    sp_q[0] <= '{close: close2_q, oss: oss_q, nss: nss_q, odot: odot_q,
                 ndot: ndot_q, ro: '0, rn: '0};
  end
  for (genvar i = 1; i <= RW; i++) begin : g_sqrt
    localparam int unsigned B = RW - i;
    logic [RW-1:0] co, cn;
    logic [2*RW-1:0] qo, qn;
    sq_t nx;
    assign co = sp_q[i-1].ro | (RW'(1) << B);
    assign cn = sp_q[i-1].rn | (RW'(1) << B);
    assign qo = co * co;
    assign qn = cn * cn;
    always_comb begin
      nx = sp_q[i-1];
      if (SW'(qo) <= sp_q[i-1].oss) nx.ro = co;
      if (SW'(qn) <= sp_q[i-1].nss) nx.rn = cn;
    end
    always_ff @(posedge clk_i) begin
      sp_q[i] <= nx;
    end
  end

  // Cosine division pipeline: restoring, one quotient bit per stage
  typedef struct packed {
    logic close;
    logic [SW-1:0] oss, nss;
    logic [CNW-1:0] ono, nno;
    logic [CDW:0] ore, nre;
    logic [CDW-1:0] ode, nde;
    logic [CNW-1:0] oq, nq;
  } cd_t;
  logic cv_q [CNW+1];
  cd_t cp_q [CNW+1];
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i <= CNW; i++) cv_q[i] <= 1'b0;
    end else begin
      cv_q[0] <= sv_q[RW];
      for (int i = 1; i <= CNW; i++) cv_q[i] <= cv_q[i-1];
    end
  end
  always_ff @(posedge clk_i) begin
    cp_q[0] <= '{close: sp_q[RW].close, oss: sp_q[RW].oss, nss: sp_q[RW].nss,
                 ono: {sp_q[RW].odot, 16'd0}, nno: {sp_q[RW].ndot, 16'd0},
                 ore: '0, nre: '0,
                 ode: {sp_q[RW].ro, {rjac_pkg::NormalFrac{1'b0}}},
                 nde: {sp_q[RW].rn, {rjac_pkg::NormalFrac{1'b0}}},
                 oq: '0, nq: '0};
  end
  for (genvar i = 1; i <= CNW; i++) begin : g_cdiv
    localparam int unsigned B = CNW - i;
    logic [CDW+1:0] to, tn;
    cd_t nx;
    assign to = {cp_q[i-1].ore, cp_q[i-1].ono[B]};
    assign tn = {cp_q[i-1].nre, cp_q[i-1].nno[B]};
    always_comb begin
      nx = cp_q[i-1];
      if (to >= (CDW+2)'(cp_q[i-1].ode)) begin
        nx.ore = (CDW+1)'(to - (CDW+2)'(cp_q[i-1].ode));
        nx.oq[B] = 1'b1;
      end else begin
        nx.ore = (CDW+1)'(to);
      end
      if (tn >= (CDW+2)'(cp_q[i-1].nde)) begin
        nx.nre = (CDW+1)'(tn - (CDW+2)'(cp_q[i-1].nde));
        nx.nq[B] = 1'b1;
      end else begin
        nx.nre = (CDW+1)'(tn);
      end
    end
    always_ff @(posedge clk_i) begin
      cp_q[i] <= nx;
    end
  end

  // Clamp cosines and grazing test
  logic [CW-1:0] cold, cnew;
  assign cold = (cp_q[CNW].oq > CNW'(65536)) ? CW'(65536) : CW'(cp_q[CNW].oq);
  assign cnew = (cp_q[CNW].nq > CNW'(65536)) ? CW'(65536) : CW'(cp_q[CNW].nq);
  typedef struct packed {
    logic close, graze;
    logic [NW-1:0] num;
    logic [QW-1:0] den;
    logic [NW:0] rem;
    logic [NW-1:0] q;
  } jd_t;
  logic mv_q;
  logic mclose_q, mgraze_q;
  logic [CW-1:0] mco_q, mcn_q;
  logic [SW-1:0] moss_q, mnss_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) mv_q <= 1'b0;
    else mv_q <= cv_q[CNW];
  end
  always_ff @(posedge clk_i) begin
    mclose_q <= cp_q[CNW].close;
    mgraze_q <= cold <= min_cos_q;
    mco_q <= cold;
    mcn_q <= cnew;
    moss_q <= cp_q[CNW].oss;
    mnss_q <= cp_q[CNW].nss;
  end

  // Partial products: cosine times each half of a squared length
  logic pv_q;
  logic pclose_q, pgraze_q;
  logic [CW+HW-1:0] nlo_q, nhi_q, dlo_q, dhi_q;
  logic [CW+SW-1:0] num_p, den_p;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) pv_q <= 1'b0;
    else pv_q <= mv_q;
  end
  always_ff @(posedge clk_i) begin
    pclose_q <= mclose_q;
    pgraze_q <= mgraze_q;
    nlo_q <= mcn_q * moss_q[HW-1:0];
    nhi_q <= mcn_q * moss_q[SW-1:HW];
    dlo_q <= mco_q * mnss_q[HW-1:0];
    dhi_q <= mco_q * mnss_q[SW-1:HW];
  end
  assign num_p = {nhi_q, {HW{1'b0}}} + (CW+SW)'(nlo_q);
  assign den_p = {dhi_q, {HW{1'b0}}} + (CW+SW)'(dlo_q);

  // Jacobian division pipeline
  logic jv_q [NW+1];
  jd_t jp_q [NW+1];
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i <= NW; i++) jv_q[i] <= 1'b0;
    end else begin
      jv_q[0] <= pv_q;
      for (int i = 1; i <= NW; i++) jv_q[i] <= jv_q[i-1];
    end
  end
  always_ff @(posedge clk_i) begin
    jp_q[0] <= '{close: pclose_q, graze: pgraze_q,
                 num: {num_p, 16'd0}, den: den_p,
                 rem: '0, q: '0};
  end
  for (genvar i = 1; i <= NW; i++) begin : g_jdiv
    localparam int unsigned B = NW - i;
    logic [NW+1:0] t;
    jd_t nx;
    assign t = {jp_q[i-1].rem, jp_q[i-1].num[B]};
    always_comb begin
      nx = jp_q[i-1];
      if (t >= (NW+2)'(jp_q[i-1].den)) begin
        nx.rem = (NW+1)'(t - (NW+2)'(jp_q[i-1].den));
        nx.q[B] = 1'b1;
      end else begin
        nx.rem = (NW+1)'(t);
      end
    end
    always_ff @(posedge clk_i) begin
      jp_q[i] <= nx;
    end
  end

  // Output register
  logic done_q;
  logic [31:0] jac_q;
  rjac_pkg::outcome_e out_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) done_q <= 1'b0;
    else done_q <= jv_q[NW];
  end
  always_ff @(posedge clk_i) begin
    if (jp_q[NW].close) begin
      jac_q <= 32'd65536; out_q <= rjac_pkg::OutTooClose;
    end else if (jp_q[NW].graze) begin
      jac_q <= 32'd0; out_q <= rjac_pkg::OutGrazing;
    end else if (jp_q[NW].q > NW'(32'hFFFF_FFFF)) begin
      jac_q <= 32'hFFFF_FFFF; out_q <= rjac_pkg::OutSaturated;
    end else begin
      jac_q <= jp_q[NW].q[31:0]; out_q <= rjac_pkg::OutNormal;
    end
  end
  assign done_o = done_q;
  assign jacobian_o = jac_q;
  assign outcome_o = out_q;

  // Checks
  `ASSERT_IMPLIES(a_close_one, clk_i, rst_ni, done_o && outcome_o == rjac_pkg::OutTooClose, jacobian_o == 32'd65536)
  `ASSERT_IMPLIES(a_graze_zero, clk_i, rst_ni, done_o && outcome_o == rjac_pkg::OutGrazing, jacobian_o == 32'd0)
  `ASSERT_NEXT(a_done_follows, clk_i, rst_ni, jv_q[NW], done_o)
endmodule
